[hw/rtl/topology_table_with_expiry_top_macros.svh]
// Assertion macros for the topology table.
`ifndef TOPOLOGY_TABLE_WITH_EXPIRY_TOP_MACROS_SVH
`define TOPOLOGY_TABLE_WITH_EXPIRY_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TTE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tte_pkg.sv]
// Shared types and codes for the topology table.
package tte_pkg;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_EXPIRE = 2'd2;
  localparam logic [1:0] ACT_LOOKUP = 2'd3;

  localparam logic [2:0] STS_INSERTED  = 3'd0;
  localparam logic [2:0] STS_UPDATED   = 3'd1;
  localparam logic [2:0] STS_KEPT      = 3'd2;
  localparam logic [2:0] STS_REMOVED   = 3'd3;
  localparam logic [2:0] STS_NOT_FOUND = 3'd4;
  localparam logic [2:0] STS_FULL      = 3'd5;
  localparam logic [2:0] STS_EXPIRED   = 3'd6;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] dest_addr;
    logic [31:0] last_hop_addr;
    logic [15:0] seq_num;
    logic [31:0] expiry_time;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_seq;
    logic [31:0] found_expiry;
    logic [6:0]  expired_count;
    logic [6:0]  occupancy;
  } out_item_t;

  // Flags carried by the token as it walks the chain. In the insert pass,
  // found means a free cell has already been claimed.
  typedef struct packed {
    logic act;
    logic found;
    logic updated;
    logic has_free;
  } tok_flags_t;

  // Command control broadcast to every cell.
  typedef struct packed {
    logic [1:0] op;
    logic       ins;
  } cmd_ctl_t;

endpackage

[hw/rtl/tte_cell.sv]
// One table entry with its slice of the token chain.
module tte_cell
  import tte_pkg::*;
#(
  parameter int ADDR_BITS = 32,
  parameter int TIME_BITS = 32,
  parameter int CNT_BITS  = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_ctl_t             ctl,
  input  logic [ADDR_BITS-1:0] cmd_dest,
  input  logic [ADDR_BITS-1:0] cmd_last,
  input  logic [15:0]          cmd_seq,
  input  logic [TIME_BITS-1:0] cmd_exp,
  input  logic [TIME_BITS-1:0] cmd_now,
  input  tok_flags_t           tok_in,
  input  logic [15:0]          seq_in,
  input  logic [TIME_BITS-1:0] exp_in,
  input  logic [CNT_BITS-1:0]  gone_in,
  output tok_flags_t           tok_out,
  output logic [15:0]          seq_out,
  output logic [TIME_BITS-1:0] exp_out,
  output logic [CNT_BITS-1:0]  gone_out
);

  logic                 vld;
  logic [ADDR_BITS-1:0] dst;
  logic [ADDR_BITS-1:0] lst;
  logic [15:0]          seq;
  logic [TIME_BITS-1:0] exp;

  logic                 vld_next;
  logic [ADDR_BITS-1:0] dst_next;
  logic [ADDR_BITS-1:0] lst_next;
  logic [15:0]          seq_next;
  logic [TIME_BITS-1:0] exp_next;
  tok_flags_t           tok_next;
  logic [15:0]          seq_out_next;
  logic [TIME_BITS-1:0] exp_out_next;
  logic [CNT_BITS-1:0]  gone_next;
  logic                 key_hit;

  assign key_hit = vld && (dst == cmd_dest) && (lst == cmd_last);

  always_comb begin
    vld_next     = vld;
    dst_next     = dst;
    lst_next     = lst;
    seq_next     = seq;
    exp_next     = exp;
    tok_next     = tok_in;
    seq_out_next = seq_in;
    exp_out_next = exp_in;
    gone_next    = gone_in;
    if (tok_in.act) begin
      if (ctl.op == ACT_EXPIRE) begin
        if (vld && (exp <= cmd_now)) begin
          vld_next  = 1'b0;
          gone_next = gone_in + CNT_BITS'(1);
        end
      end else if (ctl.ins) begin
        if (!tok_in.found && !vld) begin
          vld_next       = 1'b1;
          dst_next       = cmd_dest;
          lst_next       = cmd_last;
          seq_next       = cmd_seq;
          exp_next       = cmd_exp;
          tok_next.found = 1'b1;
        end
      end else begin
        if (!vld) begin
          tok_next.has_free = 1'b1;
        end
        if (key_hit && !tok_in.found) begin
          tok_next.found = 1'b1;
          unique case (ctl.op)
            ACT_ADD: begin
              if (cmd_seq > seq) begin
                seq_next         = cmd_seq;
                exp_next         = cmd_exp;
                tok_next.updated = 1'b1;
                seq_out_next     = cmd_seq;
                exp_out_next     = cmd_exp;
              end else begin
                seq_out_next = seq;
                exp_out_next = exp;
              end
            end
            ACT_REMOVE: begin
              vld_next = 1'b0;
            end
            ACT_LOOKUP: begin
              seq_out_next = seq;
              exp_out_next = exp;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= 1'b0;
      tok_out <= '0;
    end else begin
      vld     <= vld_next;
      tok_out <= tok_next;
    end
    dst      <= dst_next;
    lst      <= lst_next;
    seq      <= seq_next;
    exp      <= exp_next;
    seq_out  <= seq_out_next;
    exp_out  <= exp_out_next;
    gone_out <= gone_next;
  end

endmodule

[hw/rtl/topology_table_with_expiry_top.sv]
// A token walks the chain of TABLE_ENTRIES cells, one cell a cycle, and the result is
// taken from the last cell; a new key takes a second walk to claim the lowest free cell.
// A new item is accepted only once the result of the previous one is in the output register.
// Reset clears all valid bits and the occupancy count; there is no sweep.
module topology_table_with_expiry_top
  import tte_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int ADDR_BITS     = 32,
  parameter int TIME_BITS     = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  `include "topology_table_with_expiry_top_macros.svh"

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]           state;
  logic                 launch;
  cmd_ctl_t             ctl;
  logic [ADDR_BITS-1:0] cmd_dest;
  logic [ADDR_BITS-1:0] cmd_last;
  logic [15:0]          cmd_seq;
  logic [TIME_BITS-1:0] cmd_exp;
  logic [TIME_BITS-1:0] cmd_now;
  logic [CW-1:0]        occ;
  logic [CW-1:0]        occ_next;
  out_item_t            out_q;
  out_item_t            pend;
  out_item_t            res;

  logic [ADDR_BITS+31:0] dest_ext;
  logic [ADDR_BITS+31:0] last_ext;
  logic [TIME_BITS+31:0] exp_ext;
  logic [TIME_BITS+31:0] now_ext;

  tok_flags_t           tok  [TABLE_ENTRIES+1];
  logic [15:0]          tseq [TABLE_ENTRIES+1];
  logic [TIME_BITS-1:0] texp [TABLE_ENTRIES+1];
  logic [CW-1:0]        tgone[TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] act_vec;

  tok_flags_t           fin;
  logic                 fin_act;
  logic                 need_ins;
  logic                 out_free;
  logic [TIME_BITS+31:0] fexp_ext;
  logic [TIME_BITS+31:0] cexp_ext;
  logic [CW+6:0]        gone_ext;
  logic [CW+6:0]        occ_ext;

  assign in_ready  = (state == ST_IDLE) && !rst;
  assign out_data  = out_q;
  assign out_free  = !out_valid || out_ready;

  assign dest_ext = {{ADDR_BITS{1'b0}}, in_data.dest_addr};
  assign last_ext = {{ADDR_BITS{1'b0}}, in_data.last_hop_addr};
  assign exp_ext  = {{TIME_BITS{1'b0}}, in_data.expiry_time};
  assign now_ext  = {{TIME_BITS{1'b0}}, in_data.now_time};

  // Token injection at the head of the chain.
  assign tok[0]   = '{act: launch, found: 1'b0, updated: 1'b0, has_free: 1'b0};
  assign tseq[0]  = '0;
  assign texp[0]  = '0;
  assign tgone[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    tte_cell #(
      .ADDR_BITS(ADDR_BITS),
      .TIME_BITS(TIME_BITS),
      .CNT_BITS (CW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .cmd_dest(cmd_dest),
      .cmd_last(cmd_last),
      .cmd_seq (cmd_seq),
      .cmd_exp (cmd_exp),
      .cmd_now (cmd_now),
      .tok_in  (tok[i]),
      .seq_in  (tseq[i]),
      .exp_in  (texp[i]),
      .gone_in (tgone[i]),
      .tok_out (tok[i+1]),
      .seq_out (tseq[i+1]),
      .exp_out (texp[i+1]),
      .gone_out(tgone[i+1])
    );
    assign act_vec[i] = tok[i+1].act;
  end

  assign fin      = tok[TABLE_ENTRIES];
  assign fin_act  = fin.act && (state == ST_RUN);
  assign need_ins = (ctl.op == ACT_ADD) && !ctl.ins && !fin.found && fin.has_free;

  assign fexp_ext = {32'd0, texp[TABLE_ENTRIES]};
  assign cexp_ext = {32'd0, cmd_exp};
  assign gone_ext = {7'd0, tgone[TABLE_ENTRIES]};
  assign occ_ext  = {7'd0, occ_next};

  // Result of the item whose token has just left the last cell.
  always_comb begin
    res          = '0;
    res.status   = STS_NOT_FOUND;
    occ_next     = occ;
    unique case (ctl.op)
      ACT_ADD: begin
        if (ctl.ins) begin
          res.status       = STS_INSERTED;
          res.found_seq    = cmd_seq;
          res.found_expiry = cexp_ext[31:0];
          occ_next         = occ + CW'(1);
        end else if (fin.found) begin
          res.status       = fin.updated ? STS_UPDATED : STS_KEPT;
          res.found_seq    = tseq[TABLE_ENTRIES];
          res.found_expiry = fexp_ext[31:0];
        end else begin
          res.status = STS_FULL;
        end
      end
      ACT_REMOVE: begin
        if (fin.found) begin
          res.status = STS_REMOVED;
          occ_next   = occ - CW'(1);
        end
      end
      ACT_EXPIRE: begin
        res.status        = STS_EXPIRED;
        res.expired_count = gone_ext[6:0];
        occ_next          = occ - tgone[TABLE_ENTRIES];
      end
      ACT_LOOKUP: begin
        if (fin.found) begin
          res.status       = STS_KEPT;
          res.found_seq    = tseq[TABLE_ENTRIES];
          res.found_expiry = fexp_ext[31:0];
        end
      end
      default: begin
      end
    endcase
    res.occupancy = occ_ext[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      launch    <= 1'b0;
      ctl       <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      launch <= (in_valid && state == ST_IDLE) || (fin_act && need_ins);
      // The output register takes a new result, or the held one, whenever it is free.
      if (out_free) begin
        out_valid <= (fin_act && !need_ins) || (state == ST_HOLD);
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            ctl.op  <= in_data.action;
            ctl.ins <= 1'b0;
            state   <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (fin_act) begin
            if (need_ins) begin
              ctl.ins <= 1'b1;
            end else begin
              occ   <= occ_next;
              state <= out_free ? ST_IDLE : ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cmd_dest <= dest_ext[ADDR_BITS-1:0];
      cmd_last <= last_ext[ADDR_BITS-1:0];
      cmd_seq  <= in_data.seq_num;
      cmd_exp  <= exp_ext[TIME_BITS-1:0];
      cmd_now  <= now_ext[TIME_BITS-1:0];
    end
    if (fin_act && !need_ins) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        pend <= res;
      end
    end else if (state == ST_HOLD && out_ready) begin
      out_q <= pend;
    end
  end

  `TTE_ASSERT_IMPL(a_occ_bound, 1'b1, occ <= CW'(TABLE_ENTRIES),
    "occupancy count exceeds the table size")
  `TTE_ASSERT_IMPL(a_one_token, 1'b1, $onehot0({act_vec, launch}),
    "more than one token in the cell chain")
  `TTE_ASSERT_NEXT(a_ins_room, state == ST_RUN && fin_act && need_ins,
    occ < CW'(TABLE_ENTRIES), "insert pass started on a full table")

endmodule

[test/testbench.sv]
// Self-checking testbench for the topology table: a directed table, then random traffic.
module testbench
  import tte_pkg::*;
;
  localparam int ROUTE_SLOTS  = 64;
  localparam int KEY_POOL     = 96;
  localparam int NUM_DIRECTED = 24;
  localparam int NUM_RANDOM   = 930;
  localparam int QUIET_ITEMS  = 150;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 2 * ROUTE_SLOTS + 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  localparam logic [31:0] ZERO = 32'h0000_0000;
  localparam logic [31:0] ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    in_item_t  stim;
    logic      has_want;
    out_item_t want;
  } stim_row_t;

  localparam out_item_t NO_WANT = '0;

  // Keys: K0 = (0, 0), K1 = (ones, ones), K2 = (0, ones), K3 = (ones, 0).
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // Empty table: lookup and remove miss, expire finds nothing.
    '{'{ACT_LOOKUP, ZERO, ZERO, 16'h1234, 32'h5678, 32'h9}, 1'b1,
      '{STS_NOT_FOUND, 16'h0, ZERO, 7'd0, 7'd0}},
    '{'{ACT_REMOVE, ZERO, ZERO, 16'hFFFF, ONES, ONES}, 1'b1,
      '{STS_NOT_FOUND, 16'h0, ZERO, 7'd0, 7'd0}},
    '{'{ACT_EXPIRE, ONES, ONES, 16'hFFFF, ONES, ONES}, 1'b1,
      '{STS_EXPIRED, 16'h0, ZERO, 7'd0, 7'd0}},
    // Inserts at the extremes of sequence and expiry.
    '{'{ACT_ADD, ZERO, ZERO, 16'h0000, ZERO, ONES}, 1'b1,
      '{STS_INSERTED, 16'h0000, ZERO, 7'd0, 7'd1}},
    '{'{ACT_ADD, ONES, ONES, 16'hFFFF, ONES, ZERO}, 1'b1,
      '{STS_INSERTED, 16'hFFFF, ONES, 7'd0, 7'd2}},
    // Equal and older sequences leave the entry alone; a newer one replaces it.
    '{'{ACT_ADD, ZERO, ZERO, 16'h0000, 32'd77, ZERO}, 1'b0, NO_WANT},
    '{'{ACT_ADD, ONES, ONES, 16'h0000, 32'd5, ZERO}, 1'b0, NO_WANT},
    '{'{ACT_ADD, ZERO, ZERO, 16'h0001, 32'd100, ZERO}, 1'b0, NO_WANT},
    '{'{ACT_ADD, ZERO, ONES, 16'h8000, 32'd50, ONES}, 1'b0, NO_WANT},
    '{'{ACT_ADD, ONES, ZERO, 16'h7FFF, 32'd200, ONES}, 1'b0, NO_WANT},
    '{'{ACT_LOOKUP, ZERO, ONES, 16'hFFFF, ONES, ONES}, 1'b0, NO_WANT},
    '{'{ACT_LOOKUP, ZERO, ZERO, 16'hFFFF, ONES, ONES}, 1'b0, NO_WANT},
    // Only half of the key matches.
    '{'{ACT_LOOKUP, ZERO, 32'h1, 16'h0, ZERO, ZERO}, 1'b1,
      '{STS_NOT_FOUND, 16'h0, ZERO, 7'd0, 7'd4}},
    // Expiry one tick early, then exactly at the stored tick.
    '{'{ACT_EXPIRE, ZERO, ZERO, 16'h0, ZERO, 32'd49}, 1'b0, NO_WANT},
    '{'{ACT_EXPIRE, ZERO, ZERO, 16'h0, ZERO, 32'd50}, 1'b0, NO_WANT},
    '{'{ACT_REMOVE, ZERO, ZERO, 16'h0, ZERO, ZERO}, 1'b0, NO_WANT},
    '{'{ACT_REMOVE, ZERO, ZERO, 16'h0, ZERO, ZERO}, 1'b1,
      '{STS_NOT_FOUND, 16'h0, ZERO, 7'd0, 7'd2}},
    '{'{ACT_ADD, ZERO, ZERO, 16'h0005, 32'd10, ZERO}, 1'b0, NO_WANT},
    '{'{ACT_EXPIRE, ONES, ONES, 16'hFFFF, ONES, ZERO}, 1'b0, NO_WANT},
    '{'{ACT_ADD, ONES, ZERO, 16'h8000, ZERO, ZERO}, 1'b0, NO_WANT},
    '{'{ACT_EXPIRE, ZERO, ZERO, 16'h0, ZERO, ZERO}, 1'b0, NO_WANT},
    '{'{ACT_REMOVE, ONES, ONES, 16'h0, ZERO, ZERO}, 1'b0, NO_WANT},
    '{'{ACT_EXPIRE, ZERO, ZERO, 16'h0, ZERO, ONES}, 1'b1,
      '{STS_EXPIRED, 16'h0, ZERO, 7'd1, 7'd0}},
    '{'{ACT_LOOKUP, ONES, ONES, 16'hFFFF, ONES, ONES}, 1'b1,
      '{STS_NOT_FOUND, 16'h0, ZERO, 7'd0, 7'd0}}
  };

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Predictor copy of the table.
  bit        route_valid  [ROUTE_SLOTS];
  bit [31:0] route_dest   [ROUTE_SLOTS];
  bit [31:0] route_last   [ROUTE_SLOTS];
  bit [15:0] route_seq    [ROUTE_SLOTS];
  bit [31:0] route_expiry [ROUTE_SLOTS];

  bit [31:0] pool_dest [KEY_POOL];
  bit [31:0] pool_last [KEY_POOL];

  out_item_t   pending_reports [$];
  int          fail_count   = 0;
  int          fill_left    = 0;
  bit          quiet_tail   = 1'b0;
  bit          hold_outputs = 1'b0;
  int unsigned cycles_run   = 0;

  topology_table_with_expiry_top #(
    .TABLE_ENTRIES(ROUTE_SLOTS),
    .ADDR_BITS(32),
    .TIME_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int find_route(logic [31:0] dest, logic [31:0] last);
    for (int i = 0; i < ROUTE_SLOTS; i++) begin
      if (route_valid[i] && route_dest[i] == dest && route_last[i] == last) return i;
    end
    return -1;
  endfunction

  // Applies one action to the predictor table and returns the report it should give.
  function automatic out_item_t apply_topology_action(in_item_t it);
    out_item_t rep;
    int        hit;
    int        slot;
    rep = '0;
    rep.status = STS_NOT_FOUND;
    if (it.action == ACT_EXPIRE) begin
      for (int i = 0; i < ROUTE_SLOTS; i++) begin
        if (route_valid[i] && route_expiry[i] <= it.now_time) begin
          route_valid[i] = 1'b0;
          rep.expired_count++;
        end
      end
      rep.status = STS_EXPIRED;
    end else begin
      hit = find_route(it.dest_addr, it.last_hop_addr);
      if (it.action == ACT_ADD) begin
        if (hit >= 0) begin
          if (it.seq_num > route_seq[hit]) begin
            route_seq[hit] = it.seq_num;
            route_expiry[hit] = it.expiry_time;
            rep.status = STS_UPDATED;
          end else begin
            rep.status = STS_KEPT;
          end
          rep.found_seq = route_seq[hit];
          rep.found_expiry = route_expiry[hit];
        end else begin
          slot = -1;
          for (int i = ROUTE_SLOTS - 1; i >= 0; i--) begin
            if (!route_valid[i]) slot = i;
          end
          if (slot < 0) begin
            rep.status = STS_FULL;
          end else begin
            route_valid[slot] = 1'b1;
            route_dest[slot] = it.dest_addr;
            route_last[slot] = it.last_hop_addr;
            route_seq[slot] = it.seq_num;
            route_expiry[slot] = it.expiry_time;
            rep.status = STS_INSERTED;
            rep.found_seq = it.seq_num;
            rep.found_expiry = it.expiry_time;
          end
        end
      end else if (it.action == ACT_REMOVE) begin
        if (hit >= 0) begin
          route_valid[hit] = 1'b0;
          rep.status = STS_REMOVED;
        end
      end else if (hit >= 0) begin
        rep.status = STS_KEPT;
        rep.found_seq = route_seq[hit];
        rep.found_expiry = route_expiry[hit];
      end
    end
    for (int i = 0; i < ROUTE_SLOTS; i++) begin
      if (route_valid[i]) rep.occupancy++;
    end
    return rep;
  endfunction

  // Mostly actions on a pool of known keys so that updates, removes and lookups hit;
  // fill bursts push the table into the full state and end with a full expire.
  function automatic in_item_t random_route_item();
    in_item_t it;
    int       pick;
    int       k;
    int       hit;
    it.action = 2'($urandom);
    it.dest_addr = $urandom;
    it.last_hop_addr = $urandom;
    it.seq_num = 16'($urandom);
    it.expiry_time = $urandom;
    it.now_time = $urandom;
    if (fill_left > 0) begin
      fill_left--;
      if (fill_left == 0) begin
        it.action = ACT_EXPIRE;
        it.now_time = ONES;
        return it;
      end
      if (fill_left > 8) begin
        it.action = ACT_ADD;
        return it;
      end
    end
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, KEY_POOL - 1);
    if (pick < 85) begin
      it.dest_addr = pool_dest[k];
      it.last_hop_addr = pool_last[k];
    end
    if (pick < 45) begin
      it.action = ACT_ADD;
      hit = find_route(it.dest_addr, it.last_hop_addr);
      if (hit >= 0) begin
        case ($urandom_range(0, 3))
          0: it.seq_num = route_seq[hit];
          1: it.seq_num = route_seq[hit] + 16'($urandom_range(1, 3));
          default: ;
        endcase
      end
    end else if (pick < 60) begin
      it.action = ACT_LOOKUP;
    end else if (pick < 72) begin
      it.action = ACT_REMOVE;
    end else if (pick < 78) begin
      it.action = ACT_EXPIRE;
      case ($urandom_range(0, 5))
        0: it.now_time = ZERO;
        1: it.now_time = ONES;
        2, 3: begin
          hit = $urandom_range(0, ROUTE_SLOTS - 1);
          if (route_valid[hit]) it.now_time = route_expiry[hit] - 32'($urandom_range(0, 1));
        end
        default: ;
      endcase
    end else if (pick >= 85 && pick < 95) begin
      it.action = ACT_ADD;
    end
    return it;
  endfunction

  task automatic offer_item(input in_item_t stim);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= stim;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    fail_count++;
  endtask

  // Sender.
  initial begin
    in_item_t stim;
    out_item_t predicted;
    for (int k = 0; k < KEY_POOL; k++) begin
      // Odd keys share the destination of their neighbor, so only the last hop differs.
      pool_dest[k] = (k % 2 == 1) ? pool_dest[k - 1] : $urandom;
      pool_last[k] = $urandom;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int n = 0; n < NUM_DIRECTED; n++) begin
      offer_item(DIRECTED_ROWS[n].stim);
      predicted = apply_topology_action(DIRECTED_ROWS[n].stim);
      pending_reports.insert(pending_reports.size(),
                             DIRECTED_ROWS[n].has_want ? DIRECTED_ROWS[n].want : predicted);
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      quiet_tail = (n >= NUM_RANDOM - QUIET_ITEMS);
      if (n == 120) hold_outputs = 1'b1;
      if (n == 250 || n == 650) fill_left = 80;
      if (n == 500) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_reports.size() != 0);
      end
      stim = random_route_item();
      offer_item(stim);
      pending_reports.insert(pending_reports.size(), apply_topology_action(stim));
    end
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** topology_table_with_expiry_top: PASSED **");
    end else begin
      $display("** topology_table_with_expiry_top: FAILED **");
    end
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold that backs the block up.
  initial begin
    int held;
    while (rst) @(posedge clk);
    forever begin
      if (hold_outputs) begin
        hold_outputs = 1'b0;
        out_ready <= 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual %p", $time, out_data);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_data.status !== want.status)
          report_field("status", want.status, out_data.status);
        if (out_data.found_seq !== want.found_seq)
          report_field("found_seq", want.found_seq, out_data.found_seq);
        if (out_data.found_expiry !== want.found_expiry)
          report_field("found_expiry", want.found_expiry, out_data.found_expiry);
        if (out_data.expired_count !== want.expired_count)
          report_field("expired_count", want.expired_count, out_data.expired_count);
        if (out_data.occupancy !== want.occupancy)
          report_field("occupancy", want.occupancy, out_data.occupancy);
      end
    end
  end

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("** topology_table_with_expiry_top: FAILED **");
      $finish;
    end
  end

endmodule
